### hdl/bfr_pkg.sv
// Shared types, constants and glyph table for the bitmap text renderer.
// No dependencies; every other file in hdl imports this package.
package bfr_pkg;

   localparam int DispWidth  = 128;
   localparam int DispHeight = 64;
   localparam int StoreDepth = 1024;
   localparam int AddrW      = 10;
   localparam int IdxW       = 12;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_NEXT  = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   typedef struct packed {
      logic load;      // capture request beat
      logic clr_step;  // zero one store byte
      logic pix_rd;    // read store at pixel address
      logic pix_wr;    // OR pixel in, advance pixel counters
      logic byte_rd;   // read store at read_index
      logic emit;      // load result register, update cursor
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       do_draw;
      logic       clr_last;
      logic       pix_last;
      logic       out_free;
   } status_type;

   function automatic logic [2:0] glyph_row(input logic [7:0] code, input logic [2:0] row);
      logic [14:0] g;
      g = 15'd0;
      case (code)
         8'h30: g = {3'd7,3'd5,3'd5,3'd5,3'd7};
         8'h31: g = {3'd2,3'd6,3'd2,3'd2,3'd7};
         8'h32: g = {3'd7,3'd1,3'd7,3'd4,3'd7};
         8'h33: g = {3'd7,3'd1,3'd7,3'd1,3'd7};
         8'h34: g = {3'd5,3'd5,3'd7,3'd1,3'd1};
         8'h35: g = {3'd7,3'd4,3'd7,3'd1,3'd7};
         8'h36: g = {3'd7,3'd4,3'd7,3'd5,3'd7};
         8'h37: g = {3'd7,3'd1,3'd2,3'd2,3'd2};
         8'h38: g = {3'd7,3'd5,3'd7,3'd5,3'd7};
         8'h39: g = {3'd7,3'd5,3'd7,3'd1,3'd7};
         8'h41: g = {3'd2,3'd5,3'd7,3'd5,3'd5};
         8'h42: g = {3'd6,3'd5,3'd6,3'd5,3'd6};
         8'h43: g = {3'd3,3'd4,3'd4,3'd4,3'd3};
         8'h44: g = {3'd6,3'd5,3'd5,3'd5,3'd6};
         8'h45: g = {3'd7,3'd4,3'd6,3'd4,3'd7};
         8'h46: g = {3'd7,3'd4,3'd6,3'd4,3'd4};
         8'h47: g = {3'd3,3'd4,3'd5,3'd5,3'd3};
         8'h48: g = {3'd5,3'd5,3'd7,3'd5,3'd5};
         8'h49: g = {3'd7,3'd2,3'd2,3'd2,3'd7};
         8'h4A: g = {3'd1,3'd1,3'd1,3'd5,3'd2};
         8'h4B: g = {3'd5,3'd5,3'd6,3'd5,3'd5};
         8'h4C: g = {3'd4,3'd4,3'd4,3'd4,3'd7};
         8'h4D: g = {3'd5,3'd7,3'd7,3'd5,3'd5};
         8'h4E: g = {3'd5,3'd7,3'd7,3'd7,3'd5};
         8'h4F: g = {3'd2,3'd5,3'd5,3'd5,3'd2};
         8'h50: g = {3'd6,3'd5,3'd6,3'd4,3'd4};
         8'h51: g = {3'd2,3'd5,3'd5,3'd7,3'd3};
         8'h52: g = {3'd6,3'd5,3'd6,3'd5,3'd5};
         8'h53: g = {3'd3,3'd4,3'd2,3'd1,3'd6};
         8'h54: g = {3'd7,3'd2,3'd2,3'd2,3'd2};
         8'h55: g = {3'd5,3'd5,3'd5,3'd5,3'd7};
         8'h56: g = {3'd5,3'd5,3'd5,3'd5,3'd2};
         8'h57: g = {3'd5,3'd5,3'd7,3'd7,3'd5};
         8'h58: g = {3'd5,3'd5,3'd2,3'd5,3'd5};
         8'h59: g = {3'd5,3'd5,3'd2,3'd2,3'd2};
         8'h5A: g = {3'd7,3'd1,3'd2,3'd4,3'd7};
         8'h3A: g = {3'd0,3'd2,3'd0,3'd2,3'd0};
         8'h2E: g = {3'd0,3'd0,3'd0,3'd0,3'd2};
         8'h2D: g = {3'd0,3'd0,3'd7,3'd0,3'd0};
         8'h25: g = {3'd5,3'd1,3'd2,3'd4,3'd5};
         default: g = 15'd0;
      endcase
      case (row)
         3'd0: glyph_row = g[14:12];
         3'd1: glyph_row = g[11:9];
         3'd2: glyph_row = g[8:6];
         3'd3: glyph_row = g[5:3];
         3'd4: glyph_row = g[2:0];
         default: glyph_row = 3'd0;
      endcase
   endfunction

endpackage

### hdl/bfr_ctrl.sv
// Sequencer for the text renderer: clear pass, pixel read-modify-write, byte read.
// Depends on bfr_pkg.
module bfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  bfr_pkg::status_type stat,
   output bfr_pkg::cmd_type    cmd
);
   import bfr_pkg::*;

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DISP = 4'd2;
   localparam logic [3:0] S_CLR  = 4'd3;
   localparam logic [3:0] S_PRD  = 4'd4;
   localparam logic [3:0] S_PWR  = 4'd5;
   localparam logic [3:0] S_RD   = 4'd6;
   localparam logic [3:0] S_RDW  = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.op == OP_CLEAR) state_in = S_CLR;
            else if (stat.op == OP_READ) state_in = S_RD;
            else if (stat.do_draw) state_in = S_PRD;
            else state_in = S_DONE;
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_DONE;
         end
         S_PRD: begin
            cmd.pix_rd = 1'b1;
            state_in   = S_PWR;
         end
         S_PWR: begin
            cmd.pix_wr = 1'b1;
            state_in   = stat.pix_last ? S_DONE : S_PRD;
         end
         S_RD: begin
            cmd.byte_rd = 1'b1;
            state_in    = S_RDW;
         end
         S_RDW: state_in = S_DONE;
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else state_ff <= state_in;
   end

endmodule

### hdl/bfr_dp.sv
// Datapath for the text renderer: pixel store, glyph walk counters, cursor, result.
// Depends on bfr_pkg.
module bfr_dp (
   input  logic                clock,
   input  logic                reset,
   input  bfr_pkg::cmd_type    cmd,
   output bfr_pkg::status_type stat,
   input  logic [39:0]         req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata
);
   import bfr_pkg::*;

   logic [7:0] store_mem [StoreDepth];

   logic [1:0]  op_ff;
   logic [7:0]  bx_ff, y_ff, code_ff;
   logic [3:0]  scale_ff;
   logic [9:0]  ridx_ff;
   logic [2:0]  r_ff;
   logic [1:0]  c_ff;
   logic [3:0]  sx_ff, sy_ff;
   logic [AddrW-1:0] clr_ff;
   logic [7:0]  rdata_ff;
   logic [7:0]  cur_x_ff, cur_y_ff;
   logic        stop_ff, stop_in;
   logic        out_v_ff;
   logic [7:0]  out_d_ff;
   logic        out_s_ff;

   logic [7:0]  px, py;
   logic [IdxW-1:0] pidx;
   logic        pin, pon;
   logic [2:0]  bits;
   logic [7:0]  adv_x;
   logic        drawing;
   logic [3:0]  scm1;
   logic        sx_end, sy_end, c_end;

   assign px   = bx_ff + 8'(c_ff) * 8'(scale_ff) + 8'(sx_ff);
   assign py   = y_ff + 8'(r_ff) * 8'(scale_ff) + 8'(sy_ff);
   assign pidx = IdxW'(px) + IdxW'(py[7:3]) * IdxW'(DispWidth);
   assign pin  = (int'(px) < DispWidth) && (int'(py) < DispHeight)
               && (int'(pidx) < StoreDepth);
   assign bits = glyph_row(code_ff, r_ff);
   assign pon  = pin && bits[2'd2 - c_ff];

   assign scm1   = scale_ff - 4'd1;
   assign sx_end = (sx_ff == scm1);
   assign sy_end = (sy_ff == scm1);
   assign c_end  = (c_ff == 2'd2);

   assign drawing = (op_ff == OP_DRAW) || ((op_ff == OP_NEXT) && !stop_ff);
   assign adv_x   = bx_ff + 8'({scale_ff, 2'b00});
   always_comb begin
      stop_in = stop_ff;
      if (drawing) begin
         if (scale_ff == 4'd0) stop_in = 1'b1;
         else stop_in = (int'(adv_x) >= DispWidth);
      end
   end

   assign stat.op       = op_ff;
   assign stat.do_draw  = drawing && (scale_ff != 4'd0);
   assign stat.clr_last = (clr_ff == AddrW'(StoreDepth - 1));
   assign stat.pix_last = sx_end && sy_end && c_end && (r_ff == 3'd4);
   assign stat.out_free = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.clr_step) store_mem[clr_ff] <= 8'd0;
      else if (cmd.pix_wr && pon)
         store_mem[pidx[AddrW-1:0]] <= rdata_ff | (8'd1 << py[2:0]);
      if (cmd.pix_rd) rdata_ff <= store_mem[pidx[AddrW-1:0]];
      else if (cmd.byte_rd) rdata_ff <= store_mem[ridx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_tdata[1:0];
         bx_ff    <= (req_tdata[1:0] == OP_DRAW) ? req_tdata[9:2] : cur_x_ff;
         y_ff     <= req_tdata[17:10];
         code_ff  <= req_tdata[25:18];
         scale_ff <= req_tdata[29:26];
         ridx_ff  <= req_tdata[39:30];
         r_ff <= 3'd0; c_ff <= 2'd0; sx_ff <= 4'd0; sy_ff <= 4'd0;
      end else if (cmd.pix_wr) begin
         sx_ff <= sx_end ? 4'd0 : sx_ff + 4'd1;
         if (sx_end) begin
            sy_ff <= sy_end ? 4'd0 : sy_ff + 4'd1;
            if (sy_end) begin
               c_ff <= c_end ? 2'd0 : c_ff + 2'd1;
               if (c_end) r_ff <= r_ff + 3'd1;
            end
         end
      end
      if (cmd.emit) begin
         out_d_ff <= (op_ff == OP_READ) ? rdata_ff : 8'd0;
         out_s_ff <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         cur_x_ff <= 8'd0;
         cur_y_ff <= 8'd0;
         stop_ff  <= 1'b1;
         out_v_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + AddrW'(1);
         if (cmd.emit) begin
            stop_ff <= stop_in;
            if (drawing && scale_ff != 4'd0) begin
               cur_x_ff <= adv_x;
               cur_y_ff <= y_ff;
            end
         end
         if (cmd.emit) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'd0, out_s_ff, out_d_ff};

endmodule

### hdl/bitmap_font_text_renderer_unit.sv
// Top level of the bitmap text renderer: sequencer plus datapath.
// Depends on bfr_pkg, bfr_ctrl, bfr_dp.
//
// One request beat gives exactly one response beat. After reset the block
// zeroes its 1024-byte store before taking the first beat, and a clear
// request zeroes it again. A draw walks all 15 glyph cells and every scale x
// scale pixel of each with one store read and one store write; a read fetches
// one store byte, and a zero-scale or stopped draw touches no store. A
// finished response is held in an output register, so the next request is
// taken while it waits.
module bitmap_font_text_renderer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[1:0] x_pos[9:2] y_pos[17:10] char_code[25:18] scale[29:26] read_index[39:30]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0] string_stopped[8], rest zero
   output logic [15:0] rsp_tdata
);
   import bfr_pkg::*;

   cmd_type    cmd;
   status_type stat;

   bfr_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .stat, .cmd
   );

   bfr_dp u_dp (
      .clock, .reset, .cmd, .stat, .req_tdata, .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("request taken while busy");

   a_init_clear: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !req_tready) else $error("request taken before store clear");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:9] == 7'd0)) else $error("response padding not zero");

endmodule
